FILE: src/assert_macros.svh
// Assertion macros shared by the checker files of the cepstrum block.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property with reset masking.
`define LMD_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lmd assertion failed");

// Checked property that also holds through reset.
`define LMD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("lmd assertion failed");

`endif

FILE: src/lmd_pkg.sv
// Shared constants, types and the quarter-wave cosine table of the cepstrum block.
// Depends on nothing; used by every RTL file of the block except lmd_ram.
package lmd_pkg;

  localparam int MEL_CHANNELS     = 32;
  localparam int MAX_COEFFICIENTS = 16;

  localparam int DATA_W  = 32;
  localparam int IDX_W   = 4;
  localparam int COUNT_W = 5;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd12;

  localparam int BAND_W = $clog2(MEL_CHANNELS);
  localparam int CI_W   = $clog2(MAX_COEFFICIENTS);
  // Angle in units of pi/(2N), kept modulo 4N.
  localparam int A_W    = $clog2(4 * MEL_CHANNELS);
  localparam int R_W    = $clog2(MEL_CHANNELS + 1);

  localparam int LG_W   = 21;
  localparam int LG10_W = 25;
  localparam int COS_W  = 16;
  localparam int PROD_W = LG10_W + COS_W;

  localparam logic signed [LG_W-1:0] ZERO_LOG = -21'sd655360;
  localparam logic signed [29:0] LOG10_2_Q30 = 30'sd323228497;

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned TWO_N   = 64'(2 * MEL_CHANNELS);

  typedef logic signed [COS_W-1:0] qcos_tab_t [MEL_CHANNELS+1];

  // cos(pi*r/(2N)) in Q1.14, by a short Taylor series in Q30.
  function automatic logic signed [COS_W-1:0] quarter_cos(int unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint c;
    x  = PI_Q30 * 64'(r) / TWO_N;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 90;
    t  = Q30_ONE - ((x2 * t) >> 30) / 56;
    t  = Q30_ONE - ((x2 * t) >> 30) / 30;
    t  = Q30_ONE - ((x2 * t) >> 30) / 12;
    c  = longint'(Q30_ONE) - longint'(((x2 * t) >> 30) / 2);
    if (c < 0) begin
      c = 0;
    end
    return COS_W'((c + 32768) >>> 16);
  endfunction

  function automatic qcos_tab_t build_qcos();
    qcos_tab_t tab;
    for (int r = 0; r <= MEL_CHANNELS; r++) begin
      tab[r] = quarter_cos(r);
    end
    return tab;
  endfunction

  localparam qcos_tab_t QCOS_TAB = build_qcos();

endpackage

FILE: src/lmd_ifs.sv
// Valid/ready channel interfaces for the band input and the coefficient output.
// Depends on lmd_pkg for field widths.
interface lmd_in_if;
  logic                       valid;
  logic                       ready;
  logic [lmd_pkg::DATA_W-1:0] mel_energy;
  modport source (output valid, output mel_energy, input ready);
  modport sink (input valid, input mel_energy, output ready);
endinterface

interface lmd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [lmd_pkg::DATA_W-1:0] coefficient;
  logic [lmd_pkg::IDX_W-1:0]         coefficient_index;
  logic                              last_of_frame;
  modport source (output valid, output coefficient, output coefficient_index,
                  output last_of_frame, input ready);
  modport sink (input valid, input coefficient, input coefficient_index,
                input last_of_frame, output ready);
endinterface

FILE: src/log_mel_dct_cepstrum.sv
// Log-mel DCT-II cepstrum back end. Each band energy (unsigned Q16.16) is turned
// into a base-10 log by an iterative unit (normalize, squaring and scaling steps),
// then 16 multiply-accumulate passes read, update and write back the coefficient
// sums held in a 16-entry RAM, one entry per cycle, followed by a pipeline drain;
// a new band is taken only once the last is done, so the time a band takes is set
// by the log unit and the RAM's single read port. After the last band of a frame
// the RAM is swept, a read state then a load state per entry, emitting
// coefficient_count results (signed Q19.12) and clearing every entry; each read
// waits until the output register has been taken, so output stalls lengthen the
// sweep. After reset the same sweep clears the RAM before the first band is taken.
// Depends on lmd_pkg, lmd_ifs, lmd_ram and lmd_log.
module log_mel_dct_cepstrum (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        config_write,
  input  logic [lmd_pkg::COUNT_W-1:0] config_data,
  lmd_in_if.sink                      mel_in,
  lmd_out_if.source                   cep_out
);

  localparam int N = lmd_pkg::MEL_CHANNELS;
  localparam int M = lmd_pkg::MAX_COEFFICIENTS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOG   = 6'b000010,
    S_MAC   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_RD    = 6'b010000,
    S_LD    = 6'b100000
  } state_t;

  state_t                                   state;
  logic [lmd_pkg::COUNT_W-1:0]              count;
  logic [lmd_pkg::BAND_W-1:0]               band;
  logic [lmd_pkg::CI_W-1:0]                 ci;
  logic [lmd_pkg::CI_W-1:0]                 k;
  logic [lmd_pkg::COUNT_W-1:0]              n_emit;
  logic [lmd_pkg::A_W-1:0]                  angle;
  logic [lmd_pkg::A_W-1:0]                  step;
  logic signed [lmd_pkg::LG10_W-1:0]        lg10;
  logic signed [lmd_pkg::COS_W-1:0]         cos_q;
  logic                                     v1;
  logic                                     v2;
  logic [lmd_pkg::CI_W-1:0]                 i1;
  logic [lmd_pkg::CI_W-1:0]                 i2;
  logic signed [lmd_pkg::PROD_W-1:0]        prod;
  logic                                     out_valid;
  logic signed [lmd_pkg::DATA_W-1:0]        out_coef;
  logic [lmd_pkg::IDX_W-1:0]                out_idx;
  logic                                     out_last;

  logic                                     in_take;
  logic                                     log_done;
  logic signed [lmd_pkg::LG_W-1:0]          lg;
  logic [lmd_pkg::A_W:0]                    angle_sum;
  logic [lmd_pkg::A_W:0]                    a_ext;
  logic [lmd_pkg::R_W-1:0]                  r;
  logic                                     neg;
  logic signed [lmd_pkg::COS_W-1:0]         cos_next;
  logic signed [lmd_pkg::PROD_W-1:0]        prod_rnd;
  logic signed [lmd_pkg::PROD_W-19:0]       term;
  logic signed [lmd_pkg::DATA_W:0]          acc;
  logic signed [lmd_pkg::DATA_W-1:0]        acc_sat;
  logic                                     emit;
  logic                                     ram_we;
  logic [lmd_pkg::CI_W-1:0]                 ram_waddr;
  logic [lmd_pkg::DATA_W-1:0]               ram_wdata;
  logic [lmd_pkg::CI_W-1:0]                 ram_raddr;
  logic [lmd_pkg::DATA_W-1:0]               ram_rdata;
  logic [lmd_pkg::COUNT_W-1:0]              count_clamped;

  assign mel_in.ready = (state == S_IDLE);
  assign in_take      = mel_in.valid && mel_in.ready;

  assign cep_out.valid             = out_valid;
  assign cep_out.coefficient       = out_coef;
  assign cep_out.coefficient_index = out_idx;
  assign cep_out.last_of_frame     = out_last;

  lmd_log u_log (
    .clk   (clk),
    .rst   (rst),
    .start (in_take),
    .m     (mel_in.mel_energy),
    .done  (log_done),
    .lg    (lg)
  );

  // Fold the angle into the first quadrant and look up the cosine.
  always_comb begin
    a_ext = {1'b0, angle};
    if (a_ext <= (lmd_pkg::A_W+1)'(N)) begin
      r   = lmd_pkg::R_W'(a_ext);
      neg = 1'b0;
    end else if (a_ext <= (lmd_pkg::A_W+1)'(2 * N)) begin
      r   = lmd_pkg::R_W'((lmd_pkg::A_W+1)'(2 * N) - a_ext);
      neg = 1'b1;
    end else if (a_ext <= (lmd_pkg::A_W+1)'(3 * N)) begin
      r   = lmd_pkg::R_W'(a_ext - (lmd_pkg::A_W+1)'(2 * N));
      neg = 1'b1;
    end else begin
      r   = lmd_pkg::R_W'((lmd_pkg::A_W+1)'(4 * N) - a_ext);
      neg = 1'b0;
    end
    cos_next = neg ? -lmd_pkg::QCOS_TAB[r] : lmd_pkg::QCOS_TAB[r];
  end

  assign angle_sum = {1'b0, angle} + {1'b0, step};

  // Rounded term and saturating add against the sum read back from the RAM.
  assign prod_rnd = prod + lmd_pkg::PROD_W'(131072);
  assign term     = (lmd_pkg::PROD_W-18)'(prod_rnd >>> 18);
  assign acc      = (lmd_pkg::DATA_W+1)'($signed(ram_rdata)) + (lmd_pkg::DATA_W+1)'(term);
  always_comb begin
    if (acc > (lmd_pkg::DATA_W+1)'(33'sh0_7FFF_FFFF)) begin
      acc_sat = 32'sh7FFF_FFFF;
    end else if (acc < $signed(33'h1_8000_0000)) begin
      acc_sat = $signed(32'h8000_0000);
    end else begin
      acc_sat = lmd_pkg::DATA_W'(acc);
    end
  end

  always_comb begin
    if (count == '0) begin
      count_clamped = lmd_pkg::COUNT_W'(1);
    end else if (count > lmd_pkg::COUNT_W'(M)) begin
      count_clamped = lmd_pkg::COUNT_W'(M);
    end else begin
      count_clamped = count;
    end
  end

  assign emit = (lmd_pkg::COUNT_W'(k) < n_emit);

  // The accumulate pipeline and the sweep never share the RAM ports in one cycle.
  assign ram_raddr = (state == S_RD) ? k : i1;
  assign ram_we    = v2 || (state == S_LD);
  assign ram_waddr = v2 ? i2 : k;
  assign ram_wdata = v2 ? acc_sat : '0;

  lmd_ram #(
    .WIDTH (lmd_pkg::DATA_W),
    .DEPTH (M)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Payload registers of the multiply-accumulate pipeline.
  always_ff @(posedge clk) begin
    cos_q <= cos_next;
    i1    <= ci;
    prod  <= lmd_pkg::PROD_W'(lg10) * lmd_pkg::PROD_W'(cos_q);
    i2    <= i1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= lmd_pkg::COUNT_RESET;
    end else if (config_write) begin
      count <= config_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RD;
      band      <= '0;
      ci        <= '0;
      k         <= '0;
      n_emit    <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= (state == S_MAC);
      v2 <= v1;
      if (cep_out.valid && cep_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            step  <= lmd_pkg::A_W'({band, 1'b1});
            angle <= lmd_pkg::A_W'({band, 1'b1});
            state <= S_LOG;
          end
        end
        S_LOG: begin
          if (log_done) begin
            lg10  <= (lmd_pkg::LG10_W'(lg) <<< 3) + (lmd_pkg::LG10_W'(lg) <<< 1);
            ci    <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (angle_sum >= (lmd_pkg::A_W+1)'(4 * N)) begin
            angle <= lmd_pkg::A_W'(angle_sum - (lmd_pkg::A_W+1)'(4 * N));
          end else begin
            angle <= lmd_pkg::A_W'(angle_sum);
          end
          ci <= ci + 1'b1;
          if (ci == lmd_pkg::CI_W'(M - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            if (band == lmd_pkg::BAND_W'(N - 1)) begin
              band   <= '0;
              k      <= '0;
              n_emit <= count_clamped;
              state  <= S_RD;
            end else begin
              band  <= band + 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_RD: begin
          if (!out_valid) begin
            state <= S_LD;
          end
        end
        S_LD: begin
          if (emit) begin
            out_valid <= 1'b1;
            out_coef  <= $signed(ram_rdata);
            out_idx   <= lmd_pkg::IDX_W'(k);
            out_last  <= (lmd_pkg::COUNT_W'(k) + 1'b1 == n_emit);
          end
          if (k == lmd_pkg::CI_W'(M - 1)) begin
            state <= S_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/lmd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module lmd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/lmd_log.sv
// Iterative base-10 logarithm of an unsigned Q16.16 value, result in signed Q.16.
// Depends on lmd_pkg. Normalizes in five steps, then finds 16 fraction bits by squaring.
module lmd_log (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [lmd_pkg::DATA_W-1:0]       m,
  output logic                             done,
  output logic signed [lmd_pkg::LG_W-1:0]  lg
);

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_NORM = 5'b00010,
    L_SQ   = 5'b00100,
    L_MUL  = 5'b01000,
    L_FIN  = 5'b10000
  } lstate_t;

  lstate_t             state;
  logic [31:0]         y;
  logic [4:0]          p;
  logic [3:0]          cnt;
  logic [15:0]         frac;
  logic                zero;
  logic signed [50:0]  l2prod;
  logic [63:0]         sq;
  logic signed [21:0]  l2;
  logic signed [50:0]  rounded;

  assign sq      = 64'(y) * 64'(y);
  assign l2      = $signed({6'($signed({1'b0, p}) - 6'sd16), frac});
  assign rounded = l2prod + 51'sd536870912;
  assign done    = (state == L_FIN);
  assign lg      = zero ? lmd_pkg::ZERO_LOG : lmd_pkg::LG_W'(rounded >>> 30);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      case (state)
        L_IDLE: begin
          if (start) begin
            y     <= m;
            p     <= 5'd31;
            cnt   <= '0;
            zero  <= (m == '0);
            state <= L_NORM;
          end
        end
        L_NORM: begin
          // Binary search for the top set bit: 16, 8, 4, 2, 1.
          case (cnt)
            4'd0: if (y[31:16] == '0) begin y <= y << 16; p <= p - 5'd16; end
            4'd1: if (y[31:24] == '0) begin y <= y << 8;  p <= p - 5'd8;  end
            4'd2: if (y[31:28] == '0) begin y <= y << 4;  p <= p - 5'd4;  end
            4'd3: if (y[31:30] == '0) begin y <= y << 2;  p <= p - 5'd2;  end
            default: if (!y[31]) begin y <= y << 1; p <= p - 5'd1; end
          endcase
          if (cnt == 4'd4) begin
            cnt   <= '0;
            state <= L_SQ;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        L_SQ: begin
          frac <= {frac[14:0], sq[63]};
          y    <= sq[63] ? sq[63:32] : sq[62:31];
          cnt  <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= L_MUL;
          end
        end
        L_MUL: begin
          l2prod <= 51'(l2) * 51'(lmd_pkg::LOG10_2_Q30);
          state  <= L_FIN;
        end
        L_FIN: begin
          state <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/lmd_check.sv
// Port-level checker for the cepstrum block, bound to its top level.
// Depends on assert_macros.svh and lmd_pkg.
`include "assert_macros.svh"

module lmd_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [lmd_pkg::DATA_W-1:0]         coefficient,
  input logic [lmd_pkg::IDX_W-1:0]          coefficient_index,
  input logic                               last_of_frame
);

  // A stalled result transaction keeps its payload.
  `LMD_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(coefficient) && $stable(coefficient_index) && $stable(last_of_frame))

  // Reset empties the output register.
  `LMD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

  // While a frame is still being emitted no new band is taken.
  `LMD_ASSERT(a_frame_busy, clk, rst, out_valid && out_ready && !last_of_frame |=> !in_ready)

  // Index fifteen can only be the final coefficient of a frame.
  `LMD_ASSERT(a_top_index_last, clk, rst, out_valid && coefficient_index == 4'd15 |-> last_of_frame)

endmodule

bind log_mel_dct_cepstrum lmd_check u_lmd_check (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (mel_in.ready),
  .out_valid         (cep_out.valid),
  .out_ready         (cep_out.ready),
  .coefficient       (cep_out.coefficient),
  .coefficient_index (cep_out.coefficient_index),
  .last_of_frame     (cep_out.last_of_frame)
);

FILE: dv/testbench.sv
// Self-checking testbench for the log-mel DCT-II cepstrum block.
// Depends on lmd_pkg, the lmd_in_if/lmd_out_if interfaces and log_mel_dct_cepstrum.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BANDS = 32;
  localparam int COEFS = 16;
  localparam int SETTLE_CYCLES = 120;

  typedef struct {
    logic signed [31:0] value;
    logic [3:0]         index;
    logic               last;
  } cepstrum_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic config_write = 1'b0;
  logic [lmd_pkg::COUNT_W-1:0] config_data = '0;

  lmd_in_if  mel_in();
  lmd_out_if cep_out();

  log_mel_dct_cepstrum DUT (
    .clk(clk), .rst(rst), .config_write(config_write), .config_data(config_data),
    .mel_in(mel_in), .cep_out(cep_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Predictor state.
  int                 cos_q14 [COEFS][BANDS];
  logic signed [31:0] running_sums [COEFS];
  int                 bands_seen;
  logic [4:0]         emit_count;
  cepstrum_t          pending_coefs[$];
  int                 errors = 0;
  int                 frames_done = 0;
  int                 coefs_checked = 0;
  bit                 no_gaps = 0;

  function automatic int quarter_wave(longint unsigned r);
    longint unsigned x, x2, t;
    longint unsigned divisors [4];
    longint c;
    divisors = '{90, 56, 30, 12};
    x  = 64'd3373259426 * r / 64'(2 * BANDS);
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    for (int k = 0; k < 4; k++) begin
      t = (64'd1 << 30) - ((x2 * t) >> 30) / divisors[k];
    end
    c = longint'(64'd1 << 30) - longint'(((x2 * t) >> 30) / 2);
    if (c < 0) begin
      c = 0;
    end
    return int'((c + 32768) >>> 16);
  endfunction

  function automatic int cosine_entry(int i, int j);
    int a;
    a = ((i + 1) * (2 * j + 1)) % (4 * BANDS);
    if (a <= BANDS) return quarter_wave(a);
    if (a <= 2 * BANDS) return -quarter_wave(2 * BANDS - a);
    if (a <= 3 * BANDS) return -quarter_wave(a - 2 * BANDS);
    return quarter_wave(4 * BANDS - a);
  endfunction

  // Base-10 log of an unsigned Q16.16 energy, signed Q.16.
  function automatic longint log10_energy(logic [31:0] m);
    int p;
    longint unsigned y;
    longint frac, l2;
    if (m == 0) return -64'sd655360;
    p = 31;
    while (!m[p]) p--;
    y = 64'(m) << (31 - p);
    frac = 0;
    for (int b = 0; b < 16; b++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= (64'd2 << 31)) begin
        frac = frac | 1;
        y = y >> 1;
      end
    end
    l2 = (longint'(p) << 16) + frac - (64'sd16 << 16);
    return (l2 * 64'sd323228497 + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic void accumulate_band(logic [31:0] m);
    longint lg, term, s;
    int n;
    cepstrum_t c;
    lg = log10_energy(m);
    for (int i = 0; i < COEFS; i++) begin
      term = (10 * lg * longint'(cos_q14[i][bands_seen]) + (64'sd1 << 17)) >>> 18;
      s = longint'(running_sums[i]) + term;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      running_sums[i] = s[31:0];
    end
    bands_seen++;
    if (bands_seen < BANDS) return;
    bands_seen = 0;
    n = emit_count;
    if (n < 1) n = 1;
    if (n > COEFS) n = COEFS;
    for (int i = 0; i < n; i++) begin
      c.value = running_sums[i];
      c.index = i[3:0];
      c.last  = (i + 1 == n);
      pending_coefs.push_back(c);
    end
    for (int i = 0; i < COEFS; i++) running_sums[i] = '0;
  endfunction

  initial begin
    for (int i = 0; i < COEFS; i++) begin
      running_sums[i] = '0;
      for (int j = 0; j < BANDS; j++) cos_q14[i][j] = cosine_entry(i, j);
    end
    bands_seen = 0;
    emit_count = lmd_pkg::COUNT_RESET;
  end

  // Sample both channels and the register port at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (config_write) emit_count = config_data;
      if (mel_in.valid && mel_in.ready) accumulate_band(mel_in.mel_energy);
      if (cep_out.valid && cep_out.ready) begin
        if (pending_coefs.size() == 0) begin
          $error("unexpected coefficient transaction: %0d", cep_out.coefficient);
          errors++;
        end else begin
          cepstrum_t e;
          e = pending_coefs.pop_front();
          coefs_checked++;
          if (e.last) frames_done++;
          if (cep_out.coefficient !== e.value) begin
            $error("coefficient: expected %0d, actual %0d", e.value, cep_out.coefficient);
            errors++;
          end
          if (cep_out.coefficient_index !== e.index) begin
            $error("coefficient_index: expected %0d, actual %0d", e.index,
                   cep_out.coefficient_index);
            errors++;
          end
          if (cep_out.last_of_frame !== e.last) begin
            $error("last_of_frame: expected %0d, actual %0d", e.last,
                   cep_out.last_of_frame);
            errors++;
          end
        end
      end
    end
  end

  function automatic int random_gap();
    if (no_gaps) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
    return $urandom_range(0, 3);
  endfunction

  // Output stall pattern, updated at the falling edge.
  int stall_left = 0;
  initial cep_out.ready = 1'b0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      cep_out.ready = 1'b0;
    end else begin
      stall_left = random_gap();
      cep_out.ready = (stall_left == 0);
    end
  end

  initial begin
    mel_in.valid = 1'b0;
    mel_in.mel_energy = '0;
  end

  task automatic send_band(logic [31:0] m);
    int gap;
    gap = random_gap();
    if (gap > 0) begin
      mel_in.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mel_in.valid = 1'b1;
    mel_in.mel_energy = m;
    do @(posedge clk); while (!mel_in.ready);
    @(negedge clk);
    mel_in.valid = 1'b0;
  endtask

  function automatic logic [31:0] random_energy();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0001_0000;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // The register is only written once the block has drained.
  task automatic write_count(logic [4:0] value);
    while (pending_coefs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    config_write = 1'b1;
    config_data = value;
    @(negedge clk);
    config_write = 1'b0;
  endtask

  task automatic test_field_extremes();
    // Zero, the full range and single set bits, under the reset count.
    send_band(32'd0);
    send_band(32'hFFFF_FFFF);
    send_band(32'd1);
    send_band(32'h0001_0000);
    for (int k = 0; k < 28; k++) send_band(32'd1 << k);
  endtask

  task automatic test_count_limits();
    logic [4:0] counts [2];
    counts = '{5'd0, 5'd31};
    foreach (counts[c]) begin
      write_count(counts[c]);
      no_gaps = (c == 1);
      for (int j = 0; j < BANDS; j++) send_band(random_energy());
    end
    no_gaps = 0;
  endtask

  task automatic test_count_mid_frame();
    write_count(5'd3);
    for (int j = 0; j < 10; j++) send_band(random_energy());
    write_count(5'd9);
    for (int j = 10; j < BANDS; j++) send_band(random_energy());
  endtask

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_field_extremes();
    test_count_limits();
    test_count_mid_frame();
    waited = 0;
    while (pending_coefs.size() != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d frames and %0d coefficients: the reset count, counts 0 and 31,",
             frames_done, coefs_checked);
    $display("a count change within a frame, with random gaps and output stalls.");
    if (errors == 0 && pending_coefs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/lmd_pkg.sv
src/lmd_ifs.sv
src/lmd_ram.sv
src/lmd_log.sv
src/log_mel_dct_cepstrum.sv
src/lmd_check.sv
dv/testbench.sv
